### hw/rtl/hsl2rgb_pkg.sv
// Shared types and constants for the HSL to RGB converter.
// No dependencies; imported by the converter and its checker.
`default_nettype none

package hsl2rgb_pkg;

  localparam int FIELD_W = 16;
  localparam int NUM_CH  = 3;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Piece of the hue ramp that a channel falls on.
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

endpackage

`default_nettype wire

### hw/rtl/hsl_to_rgb_converter.sv
// Throughput: one item per cycle while the output is not stalled (out_ready high).
// Nine register stages, each with a valid bit; a stage loads when it is empty or
// the stage after it moves, so bubbles close up and a stalled output holds.
// Reset (rst_n low, synchronous) clears the valid bits only; data registers are not reset.
// HSL to RGB conversion: hue wrap, q/p levels, three ramp evaluations.
// Depends on hsl2rgb_pkg.
`default_nettype none

module hsl_to_rgb_converter
  import hsl2rgb_pkg::*;
#(
  parameter int FRAC_BITS     = 16,
  parameter int HUE_FRAC_BITS = 4
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire signed [FIELD_W-1:0]  in_hue_sixteenths,
  input  wire        [FIELD_W-1:0]  in_saturation,
  input  wire        [FIELD_W-1:0]  in_lightness,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic       [FIELD_W-1:0]  out_red,
  output logic       [FIELD_W-1:0]  out_green,
  output logic       [FIELD_W-1:0]  out_blue
);

  localparam int NST = 9;

  // Hue constants in units of 1/2^HUE_FRAC_BITS degree.
  localparam int T    = 360 << HUE_FRAC_BITS;
  localparam int W60  = 60 << HUE_FRAC_BITS;
  localparam int W120 = 120 << HUE_FRAC_BITS;
  localparam int W180 = 180 << HUE_FRAC_BITS;
  localparam int W240 = 240 << HUE_FRAC_BITS;
  localparam int C    = 32768 % T;
  localparam int TW   = $clog2(T);
  localparam int HUW  = TW + 1;
  localparam int KH   = 32;
  localparam int QHW  = 18 - $clog2(T);
  localparam int PRW  = KH + QHW;
  localparam longint unsigned MH = (64'd1 << KH) / T;

  // Level widths.
  localparam int LSW  = 32 - FRAC_BITS;
  localparam int SW   = ((LSW > 17) ? LSW : 17) + 3;
  localparam int DW   = SW - 1;
  localparam int VW   = SW + 1;
  localparam int AW   = $clog2(W60 + 1);
  localparam int MW   = DW + AW;
  localparam int XW   = DW + 4;
  localparam int PW15 = 2 * XW - 3;
  localparam longint unsigned M15 = (64'd1 << XW) / 15;
  localparam logic [31:0] HALF = 32'd1 << (FRAC_BITS - 1);
  localparam int TOP  = (FRAC_BITS >= 16) ? 65535 : ((1 << FRAC_BITS) - 1);

  logic [NST:1] v_r;
  logic [NST:1] rdy;

  always_comb begin
    rdy[NST] = !v_r[NST] || out_ready;
    for (int k = NST - 1; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = v_r[NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: offset hue to unsigned, reciprocal estimate of hue / T, L*S.
  logic [FIELD_W-1:0] hu_nxt;
  logic [PRW-1:0]     prodh_nxt;
  logic [31:0]        prodls_nxt;
  logic [FIELD_W-1:0] hu1_r, s1_r, l1_r;
  logic [QHW-1:0]     hq1_r;
  logic [LSW-1:0]     ls1_r;

  assign hu_nxt     = {~in_hue_sixteenths[FIELD_W-1], in_hue_sixteenths[FIELD_W-2:0]};
  assign prodh_nxt  = PRW'(hu_nxt) * PRW'(MH);
  assign prodls_nxt = 32'(in_lightness) * 32'(in_saturation);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      hu1_r <= hu_nxt;
      s1_r  <= in_saturation;
      l1_r  <= in_lightness;
      hq1_r <= prodh_nxt[KH +: QHW];
      ls1_r <= LSW'(prodls_nxt >> FRAC_BITS);
    end
  end

  // Stage 2: coarse remainder, q and p levels.
  logic [17:0]          r0_full;
  logic signed [SW-1:0] lx, sx, lsx, q2_nxt, p2_nxt;
  logic [HUW-1:0]       r0_2_r;
  logic signed [SW-1:0] q2_r, p2_r;
  logic                 zero2_r;
  logic [FIELD_W-1:0]   l2_r;

  always_comb begin
    r0_full = 18'(hu1_r) - 18'(hq1_r) * 18'(T);
    lx      = SW'(l1_r);
    sx      = SW'(s1_r);
    lsx     = SW'(ls1_r);
    if (32'(l1_r) < HALF) begin
      q2_nxt = lx + lsx;
    end else begin
      q2_nxt = lx + sx - lsx;
    end
    p2_nxt = (lx <<< 1) - q2_nxt;
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      r0_2_r  <= HUW'(r0_full);
      q2_r    <= q2_nxt;
      p2_r    <= p2_nxt;
      zero2_r <= (s1_r == '0);
      l2_r    <= l1_r;
    end
  end

  // Stage 3: remainder correction.
  logic [TW-1:0]        r1_3_r;
  logic signed [SW-1:0] q3_r, p3_r;
  logic                 zero3_r;
  logic [FIELD_W-1:0]   l3_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      r1_3_r  <= (r0_2_r >= HUW'(T)) ? TW'(r0_2_r - HUW'(T)) : TW'(r0_2_r);
      q3_r    <= q2_r;
      p3_r    <= p2_r;
      zero3_r <= zero2_r;
      l3_r    <= l2_r;
    end
  end

  // Stage 4: remove the unsigned offset, level difference.
  logic [TW-1:0]        hw4_r;
  logic signed [SW-1:0] d4_r, q4_r, p4_r;
  logic                 zero4_r;
  logic [FIELD_W-1:0]   l4_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      hw4_r   <= (r1_3_r >= TW'(C)) ? r1_3_r - TW'(C) : r1_3_r + TW'(T - C);
      d4_r    <= q3_r - p3_r;
      q4_r    <= q3_r;
      p4_r    <= p3_r;
      zero4_r <= zero3_r;
      l4_r    <= l3_r;
    end
  end

  // Stage 5: channel hues, ramp segment and ramp argument.
  logic [HUW-1:0]              hx, trs;
  logic [NUM_CH-1:0][TW-1:0]   t_nxt;
  seg_t                        seg_nxt [NUM_CH];
  logic [NUM_CH-1:0][AW-1:0]   a_nxt;
  seg_t                        seg5_r [NUM_CH];
  logic [NUM_CH-1:0][AW-1:0]   a5_r;
  logic [DW-1:0]               dmag5_r;
  logic                        dneg5_r;
  logic signed [SW-1:0]        q5_r, p5_r;
  logic                        zero5_r;
  logic [FIELD_W-1:0]          l5_r;

  always_comb begin
    hx  = HUW'(hw4_r);
    trs = hx + HUW'(W120);
    t_nxt[CH_RED]   = (trs >= HUW'(T)) ? TW'(trs - HUW'(T)) : TW'(trs);
    t_nxt[CH_GREEN] = hw4_r;
    t_nxt[CH_BLUE]  = (hw4_r >= TW'(W120)) ? hw4_r - TW'(W120) : hw4_r + TW'(T - W120);
    for (int c = 0; c < NUM_CH; c++) begin
      if (t_nxt[c] < TW'(W60)) begin
        seg_nxt[c] = SEG_RISE;
        a_nxt[c]   = AW'(t_nxt[c]);
      end else if (t_nxt[c] < TW'(W180)) begin
        seg_nxt[c] = SEG_HIGH;
        a_nxt[c]   = '0;
      end else if (t_nxt[c] < TW'(W240)) begin
        seg_nxt[c] = SEG_FALL;
        a_nxt[c]   = AW'(TW'(W240) - t_nxt[c]);
      end else begin
        seg_nxt[c] = SEG_LOW;
        a_nxt[c]   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      seg5_r  <= seg_nxt;
      a5_r    <= a_nxt;
      dneg5_r <= d4_r[SW-1];
      dmag5_r <= d4_r[SW-1] ? DW'(-d4_r) : DW'(d4_r);
      q5_r    <= q4_r;
      p5_r    <= p4_r;
      zero5_r <= zero4_r;
      l5_r    <= l4_r;
    end
  end

  // Stage 6: |q - p| times ramp argument.
  logic [NUM_CH-1:0][MW-1:0] m6_r;
  seg_t                      seg6_r [NUM_CH];
  logic                      dneg6_r;
  logic signed [SW-1:0]      q6_r, p6_r;
  logic                      zero6_r;
  logic [FIELD_W-1:0]        l6_r;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        m6_r[c] <= MW'(dmag5_r) * MW'(a5_r[c]);
      end
      seg6_r  <= seg5_r;
      dneg6_r <= dneg5_r;
      q6_r    <= q5_r;
      p6_r    <= p5_r;
      zero6_r <= zero5_r;
      l6_r    <= l5_r;
    end
  end

  // Stage 7: divide by 60 * 2^HUE_FRAC_BITS as a shift by 4 * 2^HUE_FRAC_BITS
  // followed by a reciprocal estimate of division by 15.
  logic [NUM_CH-1:0][XW-1:0]   x_nxt;
  logic [NUM_CH-1:0][PW15-1:0] pr_nxt;
  logic [NUM_CH-1:0][XW-1:0]   x7_r;
  logic [NUM_CH-1:0][DW-1:0]   qe7_r;
  seg_t                        seg7_r [NUM_CH];
  logic                        dneg7_r;
  logic signed [SW-1:0]        q7_r, p7_r;
  logic                        zero7_r;
  logic [FIELD_W-1:0]          l7_r;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      x_nxt[c]  = XW'(m6_r[c] >> (HUE_FRAC_BITS + 2));
      pr_nxt[c] = PW15'(x_nxt[c]) * PW15'(M15);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        x7_r[c]  <= x_nxt[c];
        qe7_r[c] <= pr_nxt[c][XW +: DW];
      end
      seg7_r  <= seg6_r;
      dneg7_r <= dneg6_r;
      q7_r    <= q6_r;
      p7_r    <= p6_r;
      zero7_r <= zero6_r;
      l7_r    <= l6_r;
    end
  end

  // Stage 8: quotient correction.
  logic [NUM_CH-1:0][XW-1:0] rem_nxt;
  logic [NUM_CH-1:0][DW-1:0] qt8_r;
  seg_t                      seg8_r [NUM_CH];
  logic                      dneg8_r;
  logic signed [SW-1:0]      q8_r, p8_r;
  logic                      zero8_r;
  logic [FIELD_W-1:0]        l8_r;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      rem_nxt[c] = x7_r[c] - XW'(qe7_r[c]) * XW'(15);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        qt8_r[c] <= (rem_nxt[c] >= XW'(15)) ? qe7_r[c] + DW'(1) : qe7_r[c];
      end
      seg8_r  <= seg7_r;
      dneg8_r <= dneg7_r;
      q8_r    <= q7_r;
      p8_r    <= p7_r;
      zero8_r <= zero7_r;
      l8_r    <= l7_r;
    end
  end

  // Stage 9: channel value, saturation, grey override; output register.
  function automatic logic [FIELD_W-1:0] sat_level(input logic signed [VW-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > $signed(VW'(TOP))) begin
      return FIELD_W'(TOP);
    end else begin
      return FIELD_W'(v);
    end
  endfunction

  logic signed [VW-1:0]           qtx, val;
  logic [NUM_CH-1:0][FIELD_W-1:0] ch_nxt;
  logic [FIELD_W-1:0]             grey;
  logic [NUM_CH-1:0][FIELD_W-1:0] ch9_r;

  always_comb begin
    grey = (l8_r > FIELD_W'(TOP)) ? FIELD_W'(TOP) : l8_r;
    qtx  = '0;
    val  = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      qtx = dneg8_r ? -$signed({2'b00, qt8_r[c]}) : $signed({2'b00, qt8_r[c]});
      case (seg8_r[c])
        SEG_RISE, SEG_FALL: val = $signed({p8_r[SW-1], p8_r}) + qtx;
        SEG_HIGH:           val = $signed({q8_r[SW-1], q8_r});
        default:            val = $signed({p8_r[SW-1], p8_r});
      endcase
      ch_nxt[c] = zero8_r ? grey : sat_level(val);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      ch9_r <= ch_nxt;
    end
  end

  assign out_red   = ch9_r[CH_RED];
  assign out_green = ch9_r[CH_GREEN];
  assign out_blue  = ch9_r[CH_BLUE];

endmodule

`default_nettype wire

### hw/rtl/hsl2rgb_checker.sv
// Port-level checks for hsl_to_rgb_converter, attached by the bind below.
// Depends on hsl2rgb_pkg.
`default_nettype none

module hsl2rgb_checker
  import hsl2rgb_pkg::*;
(
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_ready,
  input wire signed [FIELD_W-1:0] in_hue_sixteenths,
  input wire        [FIELD_W-1:0] in_saturation,
  input wire        [FIELD_W-1:0] in_lightness,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire        [FIELD_W-1:0] out_red,
  input wire        [FIELD_W-1:0] out_green,
  input wire        [FIELD_W-1:0] out_blue
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("stalled result changed");

  // With the output stage free to move, every stage can move.
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // An empty output stage never blocks the input.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output stage");

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_hsl2rgb_checker (.*);

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for hsl_to_rgb_converter: directed and random pixels with
// random idling on both handshakes, checked against an in-bench integer predictor.
// Depends on hsl2rgb_pkg and the converter RTL.
`timescale 1ns / 100ps

module tb;
  import hsl2rgb_pkg::*;

  localparam int     FRAC_BITS     = 16;
  localparam int     HUE_FRAC_BITS = 4;
  localparam longint HUE_TURN      = longint'(360) << HUE_FRAC_BITS;
  localparam longint HUE_60        = longint'(60) << HUE_FRAC_BITS;
  localparam longint HUE_120       = longint'(120) << HUE_FRAC_BITS;
  localparam longint HUE_180       = longint'(180) << HUE_FRAC_BITS;
  localparam longint HUE_240       = longint'(240) << HUE_FRAC_BITS;
  localparam longint FRAC_HALF     = longint'(1) << (FRAC_BITS - 1);
  localparam longint CODE_MAX      = (longint'(1) << FIELD_W) - 1;
  localparam int     STALL_LIMIT   = 2000;
  localparam int     RANDOM_PIXELS = 750;

  typedef struct packed {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
  } rgb_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [FIELD_W-1:0] in_hue_sixteenths = '0;
  logic        [FIELD_W-1:0] in_saturation = '0;
  logic        [FIELD_W-1:0] in_lightness = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic        [FIELD_W-1:0] out_red;
  logic        [FIELD_W-1:0] out_green;
  logic        [FIELD_W-1:0] out_blue;

  rgb_t expected_rgb[$];
  bit   idling_on = 1'b0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   pixels_sent = 0;
  int   colors_checked = 0;
  int   grey_pixels = 0;
  int   mismatches = 0;

  hsl_to_rgb_converter #(
    .FRAC_BITS(FRAC_BITS),
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_hue_sixteenths(in_hue_sixteenths),
    .in_saturation(in_saturation),
    .in_lightness(in_lightness),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint wrap_hue(longint v);
    longint r;
    r = v % HUE_TURN;
    if (r < 0) begin
      r += HUE_TURN;
    end
    return r;
  endfunction

  function automatic longint hue_ramp(longint p, longint q, longint v);
    longint t;
    t = wrap_hue(v);
    if (t < HUE_60) begin
      return p + ((q - p) * t) / HUE_60;
    end
    if (t < HUE_180) begin
      return q;
    end
    if (t < HUE_240) begin
      return p + ((q - p) * (HUE_240 - t)) / HUE_60;
    end
    return p;
  endfunction

  function automatic logic [FIELD_W-1:0] clamp_code(longint v);
    if (v < 0) begin
      return '0;
    end
    if (v > CODE_MAX) begin
      return CODE_MAX[FIELD_W-1:0];
    end
    return v[FIELD_W-1:0];
  endfunction

  function automatic rgb_t hsl_to_rgb(logic signed [FIELD_W-1:0] hue,
                                      logic [FIELD_W-1:0] sat, logic [FIELD_W-1:0] light);
    longint h, s, l, ls, q, p;
    rgb_t   c;
    h = wrap_hue(longint'(hue));
    s = longint'(sat);
    l = longint'(light);
    if (s == 0) begin
      c.red   = clamp_code(l);
      c.green = c.red;
      c.blue  = c.red;
      return c;
    end
    ls = (l * s) >>> FRAC_BITS;
    q  = (l < FRAC_HALF) ? l + ls : l + s - ls;
    p  = 2 * l - q;
    c.red   = clamp_code(hue_ramp(p, q, h + HUE_120));
    c.green = clamp_code(hue_ramp(p, q, h));
    c.blue  = clamp_code(hue_ramp(p, q, h - HUE_120));
    return c;
  endfunction

  task automatic report_mismatch(string field, logic [FIELD_W-1:0] got,
                                 logic [FIELD_W-1:0] want);
    mismatches++;
    if (mismatches <= 30) begin
      $display("ERROR at %0t: %s got %0d, expected %0d", $time, field, got, want);
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (!idling_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rgb_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rgb.size() == 0) begin
          report_mismatch("unexpected item", out_red, '0);
        end else begin
          want = expected_rgb.pop_front();
          if (out_red !== want.red) begin
            report_mismatch("red", out_red, want.red);
          end
          if (out_green !== want.green) begin
            report_mismatch("green", out_green, want.green);
          end
          if (out_blue !== want.blue) begin
            report_mismatch("blue", out_blue, want.blue);
          end
          colors_checked++;
        end
      end
      if (in_valid && in_ready) begin
        expected_rgb.insert(expected_rgb.size(),
                            hsl_to_rgb(in_hue_sixteenths, in_saturation, in_lightness));
        pixels_sent++;
        if (in_saturation == 0) begin
          grey_pixels++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
          $display("hsl_to_rgb_converter: mismatch");
          $finish;
        end
      end
    end
  end

  task automatic send_pixel(logic signed [FIELD_W-1:0] hue, logic [FIELD_W-1:0] sat,
                            logic [FIELD_W-1:0] light);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_hue_sixteenths <= FIELD_W'($urandom);
      in_saturation <= FIELD_W'($urandom);
      in_lightness <= FIELD_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_hue_sixteenths <= hue;
    in_saturation <= sat;
    in_lightness <= light;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic test_field_extremes();
    send_pixel(16'sh8000, 16'hFFFF, 16'h8000);
    send_pixel(16'sh7FFF, 16'hFFFF, 16'h7FFF);
    send_pixel(16'sh0000, 16'h0001, 16'h0001);
    send_pixel(-16'sd1, 16'hFFFF, 16'h4000);
    send_pixel(16'sd5759, 16'h8000, 16'hC000);
    send_pixel(16'sd5760, 16'hFFFF, 16'h0000);
  endtask

  task automatic test_zero_saturation();
    send_pixel(16'sd1000, 16'h0000, 16'h0000);
    send_pixel(-16'sd3000, 16'h0000, 16'hFFFF);
    send_pixel(16'sd2880, 16'h0000, 16'h8000);
    send_pixel(16'sh5A5A, 16'h0000, 16'hA5A5);
  endtask

  task automatic test_ramp_breakpoints();
    send_pixel(16'sd959, 16'hC000, 16'h6000);
    send_pixel(16'sd960, 16'hC000, 16'h6000);
    send_pixel(16'sd1919, 16'hC000, 16'h9000);
    send_pixel(16'sd1920, 16'hC000, 16'h9000);
    send_pixel(16'sd2879, 16'h4000, 16'h8000);
    send_pixel(16'sd3839, 16'h4000, 16'h7FFF);
    send_pixel(16'sd3840, 16'hFFFF, 16'h8000);
    send_pixel(-16'sd1920, 16'hFFFF, 16'h8000);
  endtask

  task automatic test_full_scale();
    send_pixel(16'sd0, 16'hFFFF, 16'hFFFF);
    send_pixel(16'sd4800, 16'hFFFF, 16'hFFFE);
    send_pixel(16'sd1440, 16'hFFFF, 16'h8000);
  endtask

  task automatic test_random_pixels();
    logic signed [FIELD_W-1:0] hue;
    logic        [FIELD_W-1:0] sat;
    logic        [FIELD_W-1:0] light;
    int                        kind;
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      idling_on = (i % 250) >= 60;
      hue   = FIELD_W'($urandom);
      sat   = FIELD_W'($urandom);
      light = FIELD_W'($urandom);
      kind  = $urandom_range(0, 9);
      if (kind == 0) begin
        sat = '0;
      end else if (kind == 1) begin
        hue = FIELD_W'(($urandom_range(0, 6) * 960) + $urandom_range(0, 2) - 1
                       - 5760 * $urandom_range(0, 1));
      end else if (kind == 2) begin
        sat   = FIELD_W'(16'hFFFF - $urandom_range(0, 3));
        light = $urandom_range(0, 1) ? FIELD_W'(16'hFFFF - $urandom_range(0, 3))
                                     : FIELD_W'($urandom_range(0, 3));
      end
      send_pixel(hue, sat, light);
    end
  endtask

  task automatic finish_run();
    @(negedge clk);
    in_valid <= 1'b0;
    idling_on = 1'b0;
    while (expected_rgb.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    $display("Converted %0d pixels (%0d grey), %0d colors compared, %0d field errors.",
             pixels_sent, grey_pixels, colors_checked, mismatches);
    if (mismatches == 0 && expected_rgb.size() == 0) begin
      $display("hsl_to_rgb_converter: match");
    end else begin
      $display("hsl_to_rgb_converter: mismatch");
    end
    $finish;
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_zero_saturation();
    test_ramp_breakpoints();
    idling_on = 1'b1;
    test_full_scale();
    test_random_pixels();
    finish_run();
  end

endmodule

### filelist.f
hw/rtl/hsl2rgb_pkg.sv
hw/rtl/hsl_to_rgb_converter.sv
hw/rtl/hsl2rgb_checker.sv
sim/tb.sv
